[hw/rtl/unordered_array_table_macros.svh]
// Assertion macros used by the checker of unordered_array_table.
// No dependencies; include by bare file name.
`ifndef UNORDERED_ARRAY_TABLE_MACROS_SVH
`define UNORDERED_ARRAY_TABLE_MACROS_SVH

// Implication in the same cycle, reset-qualified.
`define UAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, reset-qualified.
`define UAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/uat_pkg.sv]
// Package for unordered_array_table: sizes, operation and status codes.
// No dependencies.
package uat_pkg;

  localparam int Capacity = 16;
  localparam int ValW     = 32;
  localparam int PosW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int ActW     = 2;
  localparam int StatW    = 2;
  localparam int InDataW  = 2 * ValW;
  localparam int OutDataW = ((CntW + PosW + 7) / 8) * 8;

  typedef enum logic [ActW-1:0] {
    ActInsert = 2'd0,
    ActDelete = 2'd1,
    ActModify = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StUnused   = 2'd3
  } status_e;

endpackage

[hw/rtl/unordered_array_table.sv]
// Insert writes the entry on acceptance; modify searches up to the match at
// position p and writes there; delete searches, then makes one move per cycle.
// Throughput: one item at a time; the next item is taken once the result is registered,
// and a stalled output holds that off; searches scale with the count.
// Reset: clears the count and handshake state; entry RAM is not cleared.
// Depends on uat_pkg.
module unordered_array_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uat_pkg::InDataW-1:0]   s_axis_tdata,  // key, new_value
  input  logic [uat_pkg::ActW-1:0]      s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uat_pkg::OutDataW-1:0]  m_axis_tdata,  // count, position
  output logic [uat_pkg::StatW-1:0]     m_axis_tuser   // status
);

  localparam int IW = uat_pkg::PosW;
  localparam int CW = uat_pkg::CntW;
  localparam int VW = uat_pkg::ValW;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SSearch = 2'd1;
  localparam logic [1:0] SShift  = 2'd2;
  localparam logic [1:0] SResp   = 2'd3;

  logic signed [VW-1:0] mem [uat_pkg::Capacity];
  logic signed [VW-1:0] rdata_q;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic signed [VW-1:0] wdata;

  logic [1:0]                 state_q, state_d;
  logic [CW-1:0]              occ_q, occ_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [IW-1:0]              cidx_q, cidx_d;
  logic [IW-1:0]              wr_q, wr_d;
  logic                       pend_q, pend_d;
  logic [uat_pkg::ActW-1:0]   act_q;
  logic signed [VW-1:0]       key_q, nv_q;
  logic [uat_pkg::StatW-1:0]  res_st_q, res_st_d;
  logic [IW-1:0]              res_pos_q, res_pos_d;
  logic                       ovalid_q, ovalid_d;
  logic [uat_pkg::StatW-1:0]  out_st_q;
  logic [IW-1:0]              out_pos_q;
  logic [CW-1:0]              out_cnt_q;
  logic                       accept, load;

  assign s_axis_tready = (state_q == SIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == SResp) && (!ovalid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    cidx_d    = cidx_q;
    wr_d      = wr_q;
    pend_d    = pend_q;
    res_st_d  = res_st_q;
    res_pos_d = res_pos_q;
    raddr     = idx_q[IW-1:0];
    we        = 1'b0;
    waddr     = wr_q;
    wdata     = rdata_q;
    ovalid_d  = ovalid_q && !m_axis_tready;

    case (state_q)
      SIdle: begin
        if (accept) begin
          idx_d     = '0;
          pend_d    = 1'b0;
          res_pos_d = '0;
          res_st_d  = uat_pkg::StNotFound;
          case (s_axis_tuser)
            uat_pkg::ActInsert: begin
              if (occ_q < CW'(uat_pkg::Capacity)) begin
                we        = 1'b1;
                waddr     = occ_q[IW-1:0];
                wdata     = s_axis_tdata[VW +: VW];
                occ_d     = occ_q + CW'(1);
                res_st_d  = uat_pkg::StDone;
                res_pos_d = occ_q[IW-1:0];
              end else begin
                res_st_d  = uat_pkg::StFull;
              end
              state_d = SResp;
            end
            uat_pkg::ActDelete, uat_pkg::ActModify: state_d = SSearch;
            default: state_d = SResp;
          endcase
        end
      end
      SSearch: begin
        if (pend_q && (rdata_q == key_q)) begin
          res_st_d  = uat_pkg::StDone;
          res_pos_d = cidx_q;
          if (act_q == uat_pkg::ActModify) begin
            we      = 1'b1;
            waddr   = cidx_q;
            wdata   = nv_q;
            state_d = SResp;
          end else begin
            idx_d   = CW'(cidx_q) + CW'(1);
            wr_d    = cidx_q;
            pend_d  = 1'b0;
            state_d = SShift;
          end
        end else if (idx_q < occ_q) begin
          raddr  = idx_q[IW-1:0];
          idx_d  = idx_q + CW'(1);
          cidx_d = idx_q[IW-1:0];
          pend_d = 1'b1;
        end else begin
          state_d = SResp;
        end
      end
      SShift: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = wr_q;
          wdata = rdata_q;
          wr_d  = wr_q + IW'(1);
        end
        if (idx_q < occ_q) begin
          raddr  = idx_q[IW-1:0];
          idx_d  = idx_q + CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            occ_d   = occ_q - CW'(1);
            state_d = SResp;
          end
        end
      end
      SResp: begin
        if (load) begin
          ovalid_d = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      occ_q    <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cidx_q    <= cidx_d;
    wr_q      <= wr_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    if (accept) begin
      act_q <= s_axis_tuser;
      key_q <= s_axis_tdata[VW-1:0];
      nv_q  <= s_axis_tdata[VW +: VW];
    end
    if (load) begin
      out_st_q  <= res_st_q;
      out_pos_q <= res_pos_q;
      out_cnt_q <= occ_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {{(uat_pkg::OutDataW - CW - IW){1'b0}}, out_pos_q, out_cnt_q};

endmodule

[hw/rtl/uat_checker.sv]
// Port-level checker for unordered_array_table, attached by bind.
// Depends on uat_pkg and unordered_array_table_macros.svh.
`include "unordered_array_table_macros.svh"

module uat_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [uat_pkg::OutDataW-1:0]  m_axis_tdata,  // count, position
  input logic [uat_pkg::StatW-1:0]     m_axis_tuser   // status
);

  localparam int CW = uat_pkg::CntW;
  localparam int IW = uat_pkg::PosW;
  localparam logic [CW-1:0] CntMax = CW'(uat_pkg::Capacity);

  logic [CW-1:0] cnt;
  logic [IW-1:0] pos;
  logic          in_take;
  logic          out_stall;
  logic          out_fail;
  logic          out_full;
  logic [uat_pkg::OutDataW+uat_pkg::StatW:0] out_word;

  assign cnt       = m_axis_tdata[CW-1:0];
  assign pos       = m_axis_tdata[CW+IW-1:CW];
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_fail  = m_axis_tvalid && (m_axis_tuser != uat_pkg::StDone);
  assign out_full  = m_axis_tvalid && (m_axis_tuser == uat_pkg::StFull);
  assign out_word  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

  `UAT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word), "stalled item changed")
  `UAT_ASSERT_NEXT(a_in_one, clk_i, rst_ni, in_take, !s_axis_tready, "input taken back to back")
  `UAT_ASSERT_SAME(a_pos_zero, clk_i, rst_ni, out_fail, pos == '0, "position not zero on failure")
  `UAT_ASSERT_SAME(a_cnt_max, clk_i, rst_ni, m_axis_tvalid, cnt <= CntMax, "count beyond capacity")
  `UAT_ASSERT_SAME(a_full_cnt, clk_i, rst_ni, out_full, cnt == CntMax, "full reported below capacity")

endmodule

bind unordered_array_table uat_checker u_uat_checker (.*);

[test/unordered_array_table_tb.sv]
// Self-checking testbench for unordered_array_table: directed and random table
// operations over the input and result streams, checked against a local model.
// Depends on uat_pkg and the unordered_array_table RTL.
module unordered_array_table_tb;

  localparam int Capacity   = uat_pkg::Capacity;
  localparam int ValW       = uat_pkg::ValW;
  localparam int PosW       = uat_pkg::PosW;
  localparam int CntW       = uat_pkg::CntW;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 2 * Capacity + 20;
  localparam int RandItems  = 450;
  localparam int HoldCycles = 300;

  typedef struct packed {
    uat_pkg::status_e st;
    logic [CntW-1:0]  cnt;
    logic [PosW-1:0]  pos;
  } table_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [uat_pkg::InDataW-1:0]  s_axis_tdata;   // key, new_value
  logic [uat_pkg::ActW-1:0]     s_axis_tuser;   // action
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [uat_pkg::OutDataW-1:0] m_axis_tdata;   // count, position
  logic [uat_pkg::StatW-1:0]    m_axis_tuser;   // status

  // local copy of the table contents
  logic [ValW-1:0] tbl_vals [Capacity];
  int              tbl_cnt;

  table_result_t expected_results [$];
  int   err_cnt    = 0;
  int   cycle_cnt  = 0;
  int   n_done     = 0;
  int   n_full     = 0;
  int   n_miss     = 0;
  int   max_fill   = 0;
  bit   send_idle  = 1'b1;
  bit   sink_idle  = 1'b1;
  bit   hold_on    = 1'b0;
  event hold_start;

  unordered_array_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // first occupied slot holding key, or tbl_cnt if absent
  function automatic int find_key(logic [ValW-1:0] key);
    int idx;
    idx = 0;
    while (idx < tbl_cnt && tbl_vals[PosW'(idx)] != key) idx++;
    return idx;
  endfunction

  function automatic table_result_t apply_table_op(uat_pkg::action_e act,
                                                   logic [ValW-1:0] key,
                                                   logic [ValW-1:0] val);
    table_result_t res;
    int            hit;
    res.st  = uat_pkg::StNotFound;
    res.pos = '0;
    case (act)
      uat_pkg::ActInsert: begin
        if (tbl_cnt < Capacity) begin
          res.pos                  = PosW'(tbl_cnt);
          tbl_vals[PosW'(tbl_cnt)] = val;
          tbl_cnt++;
          res.st                   = uat_pkg::StDone;
        end else begin
          res.st = uat_pkg::StFull;
        end
      end
      uat_pkg::ActDelete: begin
        hit = find_key(key);
        if (hit < tbl_cnt) begin
          for (int k = hit; k + 1 < tbl_cnt; k++) tbl_vals[PosW'(k)] = tbl_vals[PosW'(k + 1)];
          tbl_cnt--;
          res.pos = PosW'(hit);
          res.st  = uat_pkg::StDone;
        end
      end
      uat_pkg::ActModify: begin
        hit = find_key(key);
        if (hit < tbl_cnt) begin
          tbl_vals[PosW'(hit)] = val;
          res.pos              = PosW'(hit);
          res.st               = uat_pkg::StDone;
        end
      end
      default: ;
    endcase
    res.cnt = CntW'(tbl_cnt);
    if (tbl_cnt > max_fill) max_fill = tbl_cnt;
    return res;
  endfunction

  task automatic send_op(uat_pkg::action_e act, logic [ValW-1:0] key, logic [ValW-1:0] val);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, key};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(apply_table_op(act, key, val));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d count %0d position %0d", m_axis_tuser,
               m_axis_tdata[CntW-1:0], m_axis_tdata[CntW+PosW-1:CntW]);
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tuser !== exp_r.st) begin
          $error("status: expected %0d, actual %0d", exp_r.st, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[CntW-1:0] !== exp_r.cnt) begin
          $error("count: expected %0d, actual %0d", exp_r.cnt, m_axis_tdata[CntW-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[CntW+PosW-1:CntW] !== exp_r.pos) begin
          $error("position: expected %0d, actual %0d", exp_r.pos,
                 m_axis_tdata[CntW+PosW-1:CntW]);
          err_cnt++;
        end
        case (exp_r.st)
          uat_pkg::StDone: n_done++;
          uat_pkg::StFull: n_full++;
          default:         n_miss++;
        endcase
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always begin
    @(hold_start);
    hold_on = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_on = 1'b0;
  end

  // result receiver: per-item gaps plus the long hold-off
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) gap = sink_idle ? $urandom_range(0, 8) : 0;
      @(negedge clk_i);
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_fill_and_full();
    logic [ValW-1:0] fill [Capacity] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678, 32'hFEDC_BA98,
      32'h0000_0010, 32'h8000_0001, 32'h3333_CCCC, 32'hC001_D00D};
    for (int i = 0; i < Capacity; i++) send_op(uat_pkg::ActInsert, $urandom, fill[PosW'(i)]);
    send_op(uat_pkg::ActInsert, 32'h0, 32'hDEAD_BEEF);
  endtask

  task automatic test_search_ops();
    logic [ValW-1:0] last_val;
    // duplicate key: first match, then the second one
    send_op(uat_pkg::ActModify, 32'h7FFF_FFFF, 32'h0BAD_F00D);
    send_op(uat_pkg::ActModify, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(uat_pkg::ActModify, 32'h0000_0BAD, 32'hFFFF_FFFF);
    send_op(uat_pkg::ActNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(uat_pkg::ActDelete, 32'h8000_0000, 32'h0);
    last_val = tbl_vals[PosW'(tbl_cnt - 1)];
    send_op(uat_pkg::ActDelete, last_val, 32'h0);
    // the deleted value lingers past the count and must not match
    send_op(uat_pkg::ActModify, last_val, 32'h1111_1111);
    send_op(uat_pkg::ActDelete, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(uat_pkg::ActDelete, 32'h0000_0BAD, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_ops();
    int               sent;
    int               r;
    bit               filling;
    uat_pkg::action_e act;
    logic [ValW-1:0]  key;
    logic [ValW-1:0]  val;
    sent    = 0;
    filling = 1'b1;
    while (sent < RandItems) begin
      send_idle = !(sent >= 200 && sent < 280);
      sink_idle = send_idle;
      if (tbl_cnt >= Capacity && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (tbl_cnt == 0) filling = 1'b1;
      r   = $urandom_range(0, 99);
      val = ($urandom_range(0, 1) == 0) ? ValW'($signed($urandom_range(0, 7)) - 4)
                                        : ValW'($urandom);
      key = $urandom;
      if (r < 4) begin
        act = uat_pkg::ActNone;
      end else begin
        if (r < 10) begin
          act = ($urandom_range(0, 1) == 0) ? uat_pkg::ActDelete : uat_pkg::ActModify;
        end else if ($urandom_range(0, 99) < (filling ? 65 : 30)) begin
          act = uat_pkg::ActInsert;
        end else begin
          act = ($urandom_range(0, 1) == 0) ? uat_pkg::ActDelete : uat_pkg::ActModify;
          if (tbl_cnt > 0) key = tbl_vals[PosW'($urandom_range(0, tbl_cnt - 1))];
        end
        sent++;
      end
      send_op(act, key, val);
    end
    send_idle = 1'b1;
    sink_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    logic [ValW-1:0] key;
    send_idle = 1'b0;
    -> hold_start;
    for (int i = 0; i < 30; i++) begin
      key = (tbl_cnt > 0) ? tbl_vals[PosW'($urandom_range(0, tbl_cnt - 1))] : ValW'($urandom);
      send_op((i % 3 == 2) ? uat_pkg::ActDelete : uat_pkg::ActInsert, key, $urandom);
    end
    send_idle = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    tbl_cnt       = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_and_full();
    test_search_ops();
    test_random_ops();
    test_backpressure();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      err_cnt++;
    end
    $display("checked %0d results: %0d done, %0d full, %0d not found", n_done + n_full +
             n_miss, n_done, n_full, n_miss);
    $display("table fill reached %0d of %0d entries, with a long output stall",
             max_fill, Capacity);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/uat_pkg.sv
hw/rtl/unordered_array_table.sv
hw/rtl/uat_checker.sv
test/unordered_array_table_tb.sv
